// ===== src/height_to_normal_map_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the height-to-normal-map core
// Clocked on clk; the checked form is dropped when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_TO_NORMAL_MAP_CORE_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_CORE_ASSERT_SVH
`ifndef SYNTH
// check outside of reset
`define HNM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hnm assertion failed");
// check during and after reset
`define HNM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hnm reset assertion failed");
`else
`define HNM_ASSERT(lbl, prop)
`define HNM_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/hnm_pkg.sv =====
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the height-to-normal-map core.
// ----------------------------------------------------------------------------
`default_nettype none

package hnm_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SIDE_LENGTH = 2'd0;
  localparam logic [1:0] REG_X_GAIN      = 2'd1;
  localparam logic [1:0] REG_Y_GAIN      = 2'd2;
  localparam logic [1:0] REG_Z_TERM      = 2'd3;

  localparam logic [7:0] MID_CODE = 8'd127;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MUL,
    OP_SHIFT,
    OP_SQUARE,
    OP_RINIT,
    OP_ROOT,
    OP_DINIT,
    OP_DSTEP,
    OP_EMIT
  } hnm_op_t;

  typedef struct packed {
    hnm_op_t    op;
    logic [4:0] idx;
    logic [1:0] comp;
  } hnm_cmd_t;

  typedef struct packed {
    logic jobs_any;
    logic jobs_more;
    logic fits;
    logic out_free;
  } hnm_status_t;

endpackage

`default_nettype wire

// ===== src/height_to_normal_map_core.sv =====
// ----------------------------------------------------------------------------
// height_to_normal_map_core
// Flow: each pixel of a sample runs through the shared datapath in turn: scaling,
// a 31-step square root and three 8-step divisions. A new sample is taken only
// once every pixel of the last one is out; a sample on row 0 yields no pixel,
// one on the last row up to three pixels.
// Reset: synchronous; configuration and control registers return to defaults, frame restarts at (0,0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "height_to_normal_map_core_assert.svh"

module height_to_normal_map_core import hnm_pkg::*; #(
  parameter int MAX_SIDE = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               height_valid,
  output logic                    height_ready,
  input  wire logic signed [15:0] height_sample,
  output logic                    normal_valid,
  input  wire logic               normal_ready,
  output logic [7:0]              normal_x,
  output logic [7:0]              normal_y,
  output logic [7:0]              normal_z,
  output logic [6:0]              pixel_row,
  output logic [6:0]              pixel_column,
  output logic                    last_of_run
);

  hnm_cmd_t    cmd;
  hnm_status_t status;

  assign cfg_ready = 1'b1;

  hnm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .height_valid (height_valid),
    .height_ready (height_ready),
    .status       (status),
    .cmd          (cmd)
  );

  hnm_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .height_sample (height_sample),
    .normal_valid  (normal_valid),
    .normal_ready  (normal_ready),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .pixel_row     (pixel_row),
    .pixel_column  (pixel_column),
    .last_of_run   (last_of_run)
  );

  `HNM_ASSERT(a_busy_after_take, (height_valid && height_ready) |=> !height_ready)
  `HNM_ASSERT(a_code_range, normal_valid |-> (normal_x != 8'd255 && normal_y != 8'd255 && normal_z != 8'd255))
  `HNM_ASSERT_RST(a_reset_empty, rst |=> !normal_valid)

endmodule

`default_nettype wire

// ===== src/hnm_datapath.sv =====
// ----------------------------------------------------------------------------
// hnm_datapath
// Row store, position tracking, scaling, shared square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module hnm_datapath import hnm_pkg::*; #(
  parameter int MAX_SIDE = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hnm_cmd_t           cmd,
  output hnm_status_t             status,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic signed [15:0] height_sample,
  output logic                    normal_valid,
  input  wire logic               normal_ready,
  output logic [7:0]              normal_x,
  output logic [7:0]              normal_y,
  output logic [7:0]              normal_z,
  output logic [6:0]              pixel_row,
  output logic [6:0]              pixel_column,
  output logic                    last_of_run
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);

  // configuration
  logic [7:0]  side_length;
  logic [23:0] x_gain;
  logic [23:0] y_gain;
  logic [23:0] z_term;

  logic [10:0]   side_ext;
  logic [SW-1:0] side_used;
  logic [SW-1:0] side_m1;
  logic [CW-1:0] last_idx;

  always_comb begin
    side_ext = {3'b000, side_length};
    if (side_ext < 11'd2) begin
      side_used = SW'(2);
    end else if (side_ext > 11'(MAX_SIDE)) begin
      side_used = SW'(MAX_SIDE);
    end else begin
      side_used = SW'(side_ext);
    end
    side_m1  = side_used - SW'(1);
    last_idx = side_m1[CW-1:0];
  end

  // position and sample history
  logic signed [15:0] row_store [MAX_SIDE];
  logic [CW-1:0]      row_cnt;
  logic [CW-1:0]      col_cnt;
  logic [CW-1:0]      row_q;
  logic [CW-1:0]      col_q;
  logic               last_col_q;
  logic signed [15:0] above_q;
  logic signed [15:0] right_q;
  logic signed [15:0] h_q;
  logic signed [15:0] ps_old;
  logic signed [15:0] prev_sample;
  logic signed [15:0] prf;
  logic signed [15:0] crf;
  logic [2:0]         jobs;
  logic [2:0]         jobs_low;
  logic               at_last_col;
  logic               at_last_row;
  logic               cfg_write;
  logic               out_load;

  assign at_last_col = (col_cnt == last_idx);
  assign at_last_row = (row_cnt == last_idx);
  assign cfg_write   = cfg_valid && cfg_ready;
  assign jobs_low    = jobs & (~jobs + 3'd1);
  assign out_load    = (cmd.op == OP_EMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      row_store[col_cnt] <= height_sample;
      above_q            <= row_store[col_cnt];
      right_q            <= row_store[col_cnt + CW'(1)];
      h_q                <= height_sample;
      ps_old             <= prev_sample;
      row_q              <= row_cnt;
      col_q              <= col_cnt;
      last_col_q         <= at_last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= 8'd100;
      x_gain      <= 24'd1054139;
      y_gain      <= 24'd527069;
      z_term      <= 24'd33117;
      row_cnt     <= '0;
      col_cnt     <= '0;
      prev_sample <= '0;
      prf         <= '0;
      crf         <= '0;
      jobs        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SIDE_LENGTH: begin
            side_length <= cfg_data[7:0];
            row_cnt     <= '0;
            col_cnt     <= '0;
          end
          REG_X_GAIN: x_gain <= cfg_data;
          REG_Y_GAIN: y_gain <= cfg_data;
          REG_Z_TERM: z_term <= cfg_data;
          default: ;
        endcase
      end else if (cmd.op == OP_ACCEPT) begin
        prev_sample <= height_sample;
        if (col_cnt == '0) begin
          prf <= crf;
          crf <= height_sample;
        end
        jobs <= {at_last_row && at_last_col, at_last_row && (col_cnt != '0),
                 row_cnt != '0};
        if (at_last_col) begin
          col_cnt <= '0;
          row_cnt <= at_last_row ? '0 : row_cnt + CW'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (out_load) begin
        jobs <= jobs & ~jobs_low;
      end
    end
  end

  // current job: pixel above, pixel to the left on the last row, final pixel
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [CW-1:0]      job_row;
  logic [CW-1:0]      job_col;
  logic signed [15:0] right_sel;

  always_comb begin
    right_sel = last_col_q ? prf : right_q;
    if (jobs[0]) begin
      dx      = 17'(right_sel) - 17'(above_q);
      dy      = 17'(h_q) - 17'(above_q);
      job_row = row_q - CW'(1);
      job_col = col_q;
    end else if (jobs[1]) begin
      dx      = 17'(h_q) - 17'(ps_old);
      dy      = '0;
      job_row = row_q;
      job_col = col_q - CW'(1);
    end else begin
      dx      = 17'(crf) - 17'(h_q);
      dy      = '0;
      job_row = row_q;
      job_col = col_q;
    end
  end

  logic [16:0] ax_full;
  logic [16:0] ay_full;
  logic [39:0] prod_x;
  logic [39:0] prod_y;

  assign ax_full = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay_full = dy[16] ? 17'(-dy) : 17'(dy);
  assign prod_x  = ax_full[15:0] * x_gain;
  assign prod_y  = ay_full[15:0] * y_gain;

  // scaled magnitudes and normalization
  logic [39:0] mx;
  logic [39:0] my;
  logic [39:0] mz;
  logic        nx;
  logic        ny;
  logic [61:0] acc;
  logic [61:0] rv;
  logic [61:0] res;
  logic [61:0] rbit;
  logic [39:0] rem;
  logic [7:0]  q;
  logic [7:0]  rx;
  logic [7:0]  ry;
  logic [7:0]  rz;

  logic [29:0] sq_in;
  logic [59:0] sq;
  logic [61:0] trial;
  logic [30:0] m;
  logic [29:0] mag;
  logic        neg;
  logic [31:0] base;
  logic [39:0] dsh;
  logic        qb;

  assign status.fits = ~|{mx[39:30], my[39:30], mz[39:30]};
  assign sq    = sq_in * sq_in;
  assign trial = res + rbit;
  assign m     = res[30:0];
  assign dsh   = 40'(m) << cmd.idx[2:0];
  assign qb    = (rem >= dsh);

  always_comb begin
    case (cmd.idx[1:0])
      2'd0:    sq_in = mx[29:0];
      2'd1:    sq_in = my[29:0];
      default: sq_in = mz[29:0];
    endcase
    case (cmd.comp)
      2'd0: begin
        mag = mx[29:0];
        neg = nx;
      end
      2'd1: begin
        mag = my[29:0];
        neg = ny;
      end
      default: begin
        mag = mz[29:0];
        neg = 1'b0;
      end
    endcase
    base = neg ? 32'(m) - 32'(mag) : 32'(m) + 32'(mag);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_MUL: begin
        mx <= prod_x;
        my <= prod_y;
        mz <= {2'b00, z_term, 14'd0};
        nx <= !dx[16] && (dx != '0);
        ny <= dy[16];
      end
      OP_SHIFT: begin
        if (!status.fits) begin
          mx <= mx >> 1;
          my <= my >> 1;
          mz <= mz >> 1;
        end
      end
      OP_SQUARE: acc <= ((cmd.idx == '0) ? '0 : acc) + 62'(sq);
      OP_RINIT: begin
        rv   <= acc;
        res  <= '0;
        rbit <= 62'(1) << 60;
      end
      OP_ROOT: begin
        if (rv >= trial) begin
          rv  <= rv - trial;
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
      end
      OP_DINIT: begin
        rem <= (40'(base) << 7) - 40'(base);
        q   <= '0;
      end
      OP_DSTEP: begin
        if (qb) begin
          rem <= rem - dsh;
        end
        q <= {q[6:0], qb};
        if (cmd.idx == '0) begin
          case (cmd.comp)
            2'd0:    rx <= {q[6:0], qb};
            2'd1:    ry <= {q[6:0], qb};
            default: rz <= {q[6:0], qb};
          endcase
        end
      end
      default: ;
    endcase
  end

  // output register
  logic [10:0] row_ext;
  logic [10:0] col_ext;

  assign row_ext = 11'(job_row);
  assign col_ext = 11'(job_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (out_load) begin
      normal_valid <= 1'b1;
    end else if (normal_ready) begin
      normal_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (m == '0) begin
        normal_x <= MID_CODE;
        normal_y <= MID_CODE;
        normal_z <= MID_CODE;
      end else begin
        normal_x <= rx;
        normal_y <= ry;
        normal_z <= rz;
      end
      pixel_row    <= row_ext[6:0];
      pixel_column <= col_ext[6:0];
      last_of_run  <= !status.jobs_more;
    end
  end

  assign status.jobs_any  = |jobs;
  assign status.jobs_more = ($countones(jobs) > 1);
  assign status.out_free  = !normal_valid || normal_ready;

endmodule

`default_nettype wire

// ===== src/hnm_ctrl.sv =====
// ----------------------------------------------------------------------------
// hnm_ctrl
// Sequencer for one input sample and its pixels through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module hnm_ctrl import hnm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        height_valid,
  output logic             height_ready,
  input  wire hnm_status_t status,
  output hnm_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK,
    S_MUL,
    S_SHIFT,
    S_SQUARE,
    S_RINIT,
    S_ROOT,
    S_DINIT,
    S_DSTEP,
    S_EMIT
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic [1:0] comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      comp  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (height_valid) begin
            state <= S_PICK;
          end
        end
        S_PICK:  state <= status.jobs_any ? S_MUL : S_IDLE;
        S_MUL:   state <= S_SHIFT;
        S_SHIFT: begin
          if (status.fits) begin
            state <= S_SQUARE;
            cnt   <= '0;
          end
        end
        S_SQUARE: begin
          if (cnt == 5'd2) begin
            state <= S_RINIT;
          end
          cnt <= cnt + 5'd1;
        end
        S_RINIT: begin
          state <= S_ROOT;
          cnt   <= '0;
        end
        S_ROOT: begin
          if (cnt == 5'd30) begin
            state <= S_DINIT;
            comp  <= '0;
          end
          cnt <= cnt + 5'd1;
        end
        S_DINIT: begin
          state <= S_DSTEP;
          cnt   <= 5'd7;
        end
        S_DSTEP: begin
          if (cnt == '0) begin
            if (comp == 2'd2) begin
              state <= S_EMIT;
            end else begin
              state <= S_DINIT;
              comp  <= comp + 2'd1;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_EMIT: begin
          // hold until the output register frees up
          if (status.out_free) begin
            state <= status.jobs_more ? S_MUL : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign height_ready = (state == S_IDLE);

  always_comb begin
    cmd.idx  = cnt;
    cmd.comp = comp;
    unique case (state)
      S_IDLE:   cmd.op = height_valid ? OP_ACCEPT : OP_NONE;
      S_MUL:    cmd.op = OP_MUL;
      S_SHIFT:  cmd.op = OP_SHIFT;
      S_SQUARE: cmd.op = OP_SQUARE;
      S_RINIT:  cmd.op = OP_RINIT;
      S_ROOT:   cmd.op = OP_ROOT;
      S_DINIT:  cmd.op = OP_DINIT;
      S_DSTEP:  cmd.op = OP_DSTEP;
      S_EMIT:   cmd.op = OP_EMIT;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire
